### rtl/min_first_topological_order_core_assert.svh
// Assertion helpers shared by the ordering core modules.
// Each macro expands to one labelled concurrent assertion, clocked on the
// rising edge and disabled while the synchronous reset is asserted.
`ifndef MIN_FIRST_TOPOLOGICAL_ORDER_CORE_ASSERT_SVH
`define MIN_FIRST_TOPOLOGICAL_ORDER_CORE_ASSERT_SVH

// Same-cycle implication.
`define MFTO_ASSERT_IMPLY(name, ck, rn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MFTO_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mfto_pkg.sv
// ----------------------------------------------------------------------------
// mfto_pkg
// Shared types and codes for the minimum-first topological ordering core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfto_pkg;

  // Width of the task and count fields
  localparam int FIELD_W = 7;

  // Transaction commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Input transaction payload
  typedef struct packed {
    logic [1:0]         cmd;
    logic [FIELD_W-1:0] task_req;
    logic [FIELD_W-1:0] depends_on;
  } mfto_in_t;

  // Result transaction payload
  typedef struct packed {
    logic [FIELD_W-1:0] task_id;
    logic               last;
    logic               complete;
  } mfto_out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic ld_start;
    logic ld_wr;
    logic clr_all;
    logic run_init;
    logic scan_step;
    logic adv;
    logic send;
  } mfto_ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_end;
    logic found;
    logic pend_valid;
    logic out_free;
  } mfto_sts_t;

endpackage

`default_nettype wire

### rtl/mfto_dp.sv
// ----------------------------------------------------------------------------
// mfto_dp
// Datapath: dependency matrix memory, done marks, row scan with column clear,
// pending result and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "min_first_topological_order_core_assert.svh"

module mfto_dp import mfto_pkg::*; #(
  parameter int MAX_TASKS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [FIELD_W-1:0] cfg_wdata,
  input  wire mfto_in_t           in_data,
  input  wire mfto_ctl_t          ctl_i,
  output mfto_sts_t               sts_o,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output mfto_out_t               out_data
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  logic [FIELD_W-1:0]   task_count_r;
  logic [MAX_TASKS-1:0] mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] row_valid_r;
  logic [MAX_TASKS-1:0] rd_data_r;
  logic                 rd_valid_r;
  logic [MAX_TASKS-1:0] done_r;
  logic [CW-1:0]        c_r;
  logic [CW-1:0]        c_nxt;
  logic                 found_r;
  logic [IW-1:0]        found_idx_r;
  logic                 pend_valid_r;
  logic [IW-1:0]        pend_idx_r;
  logic                 clr_valid_r;
  logic [IW-1:0]        clr_idx_r;
  logic                 ld_ok_r;
  logic [IW-1:0]        ld_row_r;
  logic [IW-1:0]        ld_col_r;
  logic                 out_valid_r;
  mfto_out_t            out_data_r;

  logic [CW-1:0]        n_eff;
  logic [MAX_TASKS-1:0] use_mask;
  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        row_idx;
  logic [MAX_TASKS-1:0] row_q;
  logic [MAX_TASKS-1:0] clr_vec;
  logic [MAX_TASKS-1:0] ld_vec;
  logic [MAX_TASKS-1:0] scan_row;
  logic                 hit;
  logic                 all_done;
  logic                 ld_ok;
  logic                 out_free;

  // Clamp the task count to the supported range
  always_comb begin
    if (task_count_r == '0) begin
      n_eff = CW'(1);
    end else if (task_count_r > FIELD_W'(MAX_TASKS)) begin
      n_eff = CW'(MAX_TASKS);
    end else begin
      n_eff = CW'(task_count_r);
    end
  end

  // Mask of tasks in use
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      use_mask[i] = (i < int'(n_eff));
    end
  end

  // Check that both ids of a load lie in range
  assign ld_ok = (in_data.task_req != '0) && (in_data.task_req <= FIELD_W'(n_eff)) &&
                 (in_data.depends_on != '0) && (in_data.depends_on <= FIELD_W'(n_eff));

  // Select the row to read: load target or scan position
  always_comb begin
    if (ctl_i.ld_start) begin
      rd_addr = IW'(in_data.task_req - FIELD_W'(1));
    end else if (c_r < CW'(MAX_TASKS)) begin
      rd_addr = c_r[IW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  // Row under test is the one read in the previous scan cycle
  assign row_idx = IW'(c_r - CW'(1));
  assign row_q   = rd_valid_r ? rd_data_r : '0;

  // Column of the previously emitted task, and the bit of a load
  always_comb begin
    clr_vec = '0;
    ld_vec  = '0;
    if (clr_valid_r) begin
      clr_vec[clr_idx_r] = 1'b1;
    end
    ld_vec[ld_col_r] = 1'b1;
  end

  assign scan_row = row_q & ~clr_vec;
  assign hit      = (c_r != '0) && (c_r <= n_eff) && !done_r[row_idx] &&
                    ((scan_row & use_mask) == '0);
  assign all_done = ((done_r & use_mask) == use_mask);
  assign out_free = !out_valid_r || out_ready;

  // Matrix memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl_i.ld_wr && ld_ok_r) begin
      mem[ld_row_r] <= row_q | ld_vec;
    end else if (ctl_i.scan_step && (c_r != '0)) begin
      mem[row_idx] <= scan_row;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Row valid bits stand in for clearing the memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      rd_valid_r <= row_valid_r[rd_addr];
      if (ctl_i.clr_all) begin
        row_valid_r <= '0;
      end else if (ctl_i.ld_wr && ld_ok_r) begin
        row_valid_r[ld_row_r] <= 1'b1;
      end else if (ctl_i.scan_step && (c_r != '0)) begin
        row_valid_r[row_idx] <= 1'b1;
      end
    end
  end

  // Advance the scan counter, hold at the end, restart on run start or advance
  always_comb begin
    c_nxt = c_r;
    if (ctl_i.run_init || ctl_i.adv) begin
      c_nxt = '0;
    end else if (ctl_i.scan_step && (c_r != CW'(MAX_TASKS))) begin
      c_nxt = c_r + CW'(1);
    end
  end

  // Scan, emission and done-mark state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= FIELD_W'(1);
      done_r       <= '0;
      c_r          <= '0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      clr_valid_r  <= 1'b0;
      ld_ok_r      <= 1'b0;
    end else begin
      c_r <= c_nxt;
      if (cfg_we) begin
        task_count_r <= cfg_wdata;
      end
      if (ctl_i.ld_start) begin
        ld_ok_r <= ld_ok;
      end
      if (ctl_i.clr_all) begin
        done_r <= '0;
      end
      if (ctl_i.run_init) begin
        pend_valid_r <= 1'b0;
        clr_valid_r  <= 1'b0;
        found_r      <= 1'b0;
      end else if (ctl_i.adv) begin
        pend_valid_r        <= 1'b1;
        clr_valid_r         <= 1'b1;
        done_r[found_idx_r] <= 1'b1;
        found_r             <= 1'b0;
      end else if (ctl_i.scan_step && hit && !found_r) begin
        found_r <= 1'b1;
      end
    end
  end

  // Load target, and payload of the scan: found index, pending and clearing task
  always_ff @(posedge clk) begin
    if (ctl_i.ld_start) begin
      ld_row_r <= IW'(in_data.task_req - FIELD_W'(1));
      ld_col_r <= IW'(in_data.depends_on - FIELD_W'(1));
    end
    if (ctl_i.adv) begin
      pend_idx_r <= found_idx_r;
      clr_idx_r  <= found_idx_r;
    end
    if (ctl_i.scan_step && hit && !found_r) begin
      found_idx_r <= row_idx;
    end
  end

  // Output register: load on send, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl_i.send) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.send) begin
      out_data_r.task_id  <= pend_valid_r ? (FIELD_W'(pend_idx_r) + FIELD_W'(1)) : '0;
      out_data_r.last     <= !found_r;
      out_data_r.complete <= !found_r && all_done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts_o.scan_end   = (c_r == CW'(MAX_TASKS));
  assign sts_o.found      = found_r;
  assign sts_o.pend_valid = pend_valid_r;
  assign sts_o.out_free   = out_free;

  `MFTO_ASSERT_NEXT(a_done_keep, clk, rst_n, !ctl_i.clr_all, (done_r & $past(done_r)) == $past(done_r), "done mark lost without clear")
  `MFTO_ASSERT_IMPLY(a_send_pend, clk, rst_n, ctl_i.send && found_r, pend_valid_r, "non-final result sent with nothing pending")

endmodule

`default_nettype wire

### rtl/mfto_ctrl.sv
// ----------------------------------------------------------------------------
// mfto_ctrl
// Controller: takes transactions, sequences loads, scans and result sends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "min_first_topological_order_core_assert.svh"

module mfto_ctrl import mfto_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_cmd,
  output logic            in_ready,
  input  wire mfto_sts_t  sts_i,
  output mfto_ctl_t       ctl_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LD_WR = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_SEND  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctl_o     = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_LOAD: begin
              ctl_o.ld_start = 1'b1;
              state_nxt      = S_LD_WR;
            end
            CMD_RUN: begin
              ctl_o.run_init = 1'b1;
              state_nxt      = S_SCAN;
            end
            CMD_CLEAR: begin
              ctl_o.clr_all = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_LD_WR: begin
        ctl_o.ld_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SCAN: begin
        ctl_o.scan_step = 1'b1;
        if (sts_i.scan_end) begin
          state_nxt = S_SEND;
        end
      end
      S_SEND: begin
        if (sts_i.found) begin
          // push the pending task unless this is the first hit
          if (!sts_i.pend_valid) begin
            ctl_o.adv = 1'b1;
            state_nxt = S_SCAN;
          end else if (sts_i.out_free) begin
            ctl_o.send = 1'b1;
            ctl_o.adv  = 1'b1;
            state_nxt  = S_SCAN;
          end
        end else if (sts_i.out_free) begin
          // final result of the run
          ctl_o.send = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MFTO_ASSERT_IMPLY(a_send_free, clk, rst_n, ctl_o.send, sts_i.out_free, "result sent into a full output register")
  `MFTO_ASSERT_IMPLY(a_adv_found, clk, rst_n, ctl_o.adv, sts_i.found, "advance without a ready task")

endmodule

`default_nettype wire

### rtl/min_first_topological_order_core.sv
// Minimum-first topological ordering core. A load transaction does a
// read-modify-write of one matrix row; a clear and a command 3 are both
// taken in the idle state, and a command 3 is dropped. A run with k emitted
// tasks makes k + 1 passes and can be held by output stalls: every emission
// needs one full pass over the dependency matrix through its single read
// port, which also clears the last emitted task's column, followed by a
// step to pick or send. Results leave through an
// output register, so the final result of a run may wait there while the
// next transaction is already taken.
// ----------------------------------------------------------------------------
// min_first_topological_order_core
// Top level: loads dependency edges, emits tasks in minimum-first
// topological order, flags whether a run completed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module min_first_topological_order_core import mfto_pkg::*; #(
  parameter int MAX_TASKS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [FIELD_W-1:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mfto_in_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mfto_out_t               out_data
);

  mfto_ctl_t ctl;
  mfto_sts_t sts;

  // Sequence transactions
  mfto_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .sts_i    (sts),
    .ctl_o    (ctl)
  );

  // Hold the matrix and run the scans
  mfto_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### tb/min_first_topological_order_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_first_topological_order_core_tb
// Self-checking bench for the minimum-first topological ordering core.
// Edge loads, clears and run commands are driven with random gaps against
// a randomly stalling result side. A scoreboard keeps its own dependency
// matrix and done marks, and works out the emission order of every run.
// It then checks each result transaction, in order, against that order.
// ----------------------------------------------------------------------------

module min_first_topological_order_core_tb;
  import mfto_pkg::*;

  localparam int         TASK_LIMIT    = 64;
  localparam logic [1:0] CMD_SPARE     = 2'd3;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         QUIET_LIMIT   = 6000;
  localparam int         RANDOM_ITEMS  = 145;

  // Scoreboard: mirrors the ordering state and holds the pending results
  class topo_order_scoreboard;
    logic [63:0]      dep_rows [TASK_LIMIT];
    logic [63:0]      done_bits;
    logic [6:0]       count_reg;
    mfto_out_t        order_q [$];
    int unsigned      mismatches;
    int unsigned      transactions;
    int unsigned      runs;
    int unsigned      results;

    function new();
      clear_state();
      count_reg    = 7'd1;
      mismatches   = 0;
      transactions = 0;
      runs         = 0;
      results      = 0;
    endfunction

    function void clear_state();
      foreach (dep_rows[i]) dep_rows[i] = '0;
      done_bits = '0;
    endfunction

    function void set_count(logic [6:0] value);
      count_reg = value;
    endfunction

    function int unsigned pending();
      return order_q.size();
    endfunction

    // Clamp the register to the usable range of tasks
    function int unsigned tasks_in_use();
      if (count_reg == 0) return 1;
      if (count_reg > TASK_LIMIT) return TASK_LIMIT;
      return count_reg;
    endfunction

    function logic [63:0] task_mask(int unsigned n);
      return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
    endfunction

    // Tasks not done whose dependencies within the count are all done
    function logic [63:0] ready_tasks(int unsigned n);
      logic [63:0] mask;
      logic [63:0] rdy;
      mask = task_mask(n);
      rdy  = '0;
      for (int i = 0; i < n; i++) begin
        if (!done_bits[i] && ((dep_rows[i] & mask) == 0)) rdy[i] = 1'b1;
      end
      return rdy;
    endfunction

    // Apply one accepted transaction and queue the results it causes
    function void note_transaction(mfto_in_t item);
      int unsigned n;
      int unsigned emitted;
      int          pick;
      logic [63:0] rdy;
      logic [63:0] mask;
      mfto_out_t   r;
      transactions++;
      n    = tasks_in_use();
      mask = task_mask(n);
      case (item.cmd)
        CMD_LOAD: begin
          if (item.task_req >= 1 && item.task_req <= n &&
              item.depends_on >= 1 && item.depends_on <= n)
            dep_rows[item.task_req - 1][item.depends_on - 1] = 1'b1;
        end
        CMD_CLEAR: clear_state();
        CMD_RUN: begin
          runs++;
          emitted = 0;
          rdy     = ready_tasks(n);
          while (rdy != 0 && emitted < TASK_LIMIT) begin
            pick = 0;
            for (int i = 63; i >= 0; i--) if (rdy[i]) pick = i;
            done_bits[pick] = 1'b1;
            for (int i = 0; i < TASK_LIMIT; i++) dep_rows[i][pick] = 1'b0;
            r.task_id  = 7'(pick + 1);
            r.last     = 1'b0;
            r.complete = 1'b0;
            order_q.push_back(r);
            emitted++;
            rdy = ready_tasks(n);
          end
          // close the run: flag the final result or give the empty one
          if (emitted == 0) begin
            r.task_id = '0;
          end else begin
            r = order_q.pop_back();
          end
          r.last     = 1'b1;
          r.complete = ((done_bits & mask) == mask);
          order_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(mfto_out_t got);
      mfto_out_t want;
      results++;
      if (order_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got id %0d last %0b complete %0b",
                 $time, got.task_id, got.last, got.complete);
        return;
      end
      want = order_q.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: result mismatch: expected id %0d last %0b complete %0b,",
                 $time, want.task_id, want.last, want.complete);
        $display("%0t:   got id %0d last %0b complete %0b",
                 $time, got.task_id, got.last, got.complete);
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [FIELD_W-1:0]   cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  mfto_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  mfto_out_t            out_data;

  bit                   steady       = 1'b0;
  int unsigned          quiet_cycles = 0;
  int unsigned          count_writes = 0;
  topo_order_scoreboard board        = new();

  min_first_topological_order_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Note accepted inputs, check accepted results, count quiet cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_transaction(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Stall the result side at random, except in the steady stretch
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 32);
  end

  // Watchdog on a hung handshake
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Offer one transaction after a random gap and hold it until taken
  task automatic send_transaction(input logic [1:0] cmd, input logic [6:0] req,
                                  input logic [6:0] dep);
    mfto_in_t item;
    item.cmd        = cmd;
    item.task_req   = req;
    item.depends_on = dep;
    while (!steady && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid, drain every expected result and let a last load finish
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_task_count(input logic [6:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_count(value);
    count_writes++;
  endtask

  // One random phase: optional clear, mostly acyclic edges, then runs
  task automatic random_phase(input logic [6:0] cnt, output int unsigned items);
    int unsigned n;
    int unsigned rank [TASK_LIMIT];
    int unsigned j;
    int unsigned tmp;
    int unsigned edges;
    int unsigned roll;
    int unsigned a;
    int unsigned b;
    int unsigned passes;
    int unsigned wide_id;
    items = 0;
    n = (cnt == 0) ? 1 : (cnt > TASK_LIMIT) ? TASK_LIMIT : cnt;
    for (int i = 0; i < TASK_LIMIT; i++) rank[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = rank[i]; rank[i] = rank[j]; rank[j] = tmp;
    end
    if ($urandom_range(99) < 80) begin
      send_transaction(CMD_CLEAR, 7'($urandom), 7'($urandom));
      items++;
    end
    passes = ($urandom_range(99) < 30) ? 2 : 1;
    for (int p = 0; p < passes; p++) begin
      edges = $urandom_range(12, 1);
      for (int e = 0; e < edges; e++) begin
        roll = $urandom_range(99);
        a = $urandom_range(n, 1);
        b = $urandom_range(n, 1);
        if (n >= 2) while (b == a) b = $urandom_range(n, 1);
        if (roll < 70 && a != b) begin
          // later task in the hidden ranking depends on the earlier one
          if (rank[a - 1] > rank[b - 1]) send_transaction(CMD_LOAD, 7'(a), 7'(b));
          else send_transaction(CMD_LOAD, 7'(b), 7'(a));
          items++;
        end else if (roll < 80 && a != b) begin
          // close a two-task cycle
          send_transaction(CMD_LOAD, 7'(a), 7'(b));
          send_transaction(CMD_LOAD, 7'(b), 7'(a));
          items += 2;
        end else if (roll < 85) begin
          send_transaction(CMD_LOAD, 7'(a), 7'(a));
          items++;
        end else if (roll < 93) begin
          send_transaction(2'($urandom_range(3)), 7'($urandom), 7'($urandom));
          items++;
        end else begin
          // id outside the tasks in use
          wide_id = $urandom_range(127, n + 1) * (n < 127);
          if ($urandom_range(1)) send_transaction(CMD_LOAD, 7'(wide_id), 7'(b));
          else send_transaction(CMD_LOAD, 7'(a), 7'(wide_id));
          items++;
        end
      end
      send_transaction(CMD_RUN, 7'($urandom), 7'($urandom));
      items++;
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned got;
    int unsigned sel;
    logic [6:0]  cnt;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single task after reset, then nothing left to run
    send_transaction(CMD_RUN, 7'd0, 7'd0);
    send_transaction(CMD_RUN, 7'd127, 7'd127);
    settle();
    write_task_count(7'd64);

    // Cycle, self dependency, ignored ids and a spare command at full size
    send_transaction(CMD_CLEAR, 7'd0, 7'd0);
    send_transaction(CMD_LOAD, 7'd64, 7'd1);
    send_transaction(CMD_LOAD, 7'd1, 7'd64);
    send_transaction(CMD_LOAD, 7'd2, 7'd2);
    send_transaction(CMD_LOAD, 7'd0, 7'd5);
    send_transaction(CMD_LOAD, 7'd65, 7'd3);
    send_transaction(CMD_LOAD, 7'd3, 7'd70);
    send_transaction(CMD_LOAD, 7'd127, 7'd127);
    send_transaction(CMD_LOAD, 7'd5, 7'd3);
    send_transaction(CMD_LOAD, 7'd3, 7'd4);
    send_transaction(CMD_SPARE, 7'd127, 7'd0);
    send_transaction(CMD_RUN, 7'd0, 7'd127);
    send_transaction(CMD_RUN, 7'd0, 7'd0);
    settle();

    // Count register below and above its range clamps
    write_task_count(7'd0);
    send_transaction(CMD_CLEAR, 7'd0, 7'd0);
    send_transaction(CMD_RUN, 7'd0, 7'd0);
    settle();
    write_task_count(7'd127);
    send_transaction(CMD_RUN, 7'd0, 7'd0);
    settle();

    // Edges beyond a lowered count are kept but disregarded
    write_task_count(7'd64);
    send_transaction(CMD_CLEAR, 7'd0, 7'd0);
    send_transaction(CMD_LOAD, 7'd2, 7'd10);
    send_transaction(CMD_LOAD, 7'd3, 7'd2);
    settle();
    write_task_count(7'd4);
    send_transaction(CMD_RUN, 7'd0, 7'd0);
    settle();
    write_task_count(7'd12);
    send_transaction(CMD_RUN, 7'd0, 7'd0);

    // Random phases, with a steady stretch in the middle
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      steady = (sent >= 60 && sent < 100);
      sel = $urandom_range(9);
      case (sel)
        0:       cnt = 7'd1;
        1:       cnt = 7'd64;
        2:       cnt = 7'd0;
        3:       cnt = 7'($urandom_range(127, 65));
        default: cnt = 7'($urandom_range(16, 2));
      endcase
      write_task_count(cnt);
      random_phase(cnt, got);
      sent += got;
    end
    steady = 1'b0;
    settle();

    $display("Ran %0d transactions with %0d runs over %0d task-count writes;",
             board.transactions, board.runs, count_writes);
    $display("checked %0d ordered results, %0d mismatches.", board.results, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/mfto_pkg.sv
rtl/mfto_dp.sv
rtl/mfto_ctrl.sv
rtl/min_first_topological_order_core.sv
tb/min_first_topological_order_core_tb.sv
